[rtl/core/assert_macros.svh]
// Assertion macros for the echo ranger RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/uer_pkg.sv]
// Shared types, constants and controller/datapath links for the echo ranger.
`default_nettype none

package uer_pkg;

    // Tick counter width and derived widths
    localparam int TIME_BITS   = 18;
    localparam int TRIG_W      = 10;
    localparam int TMO_W       = 16;
    localparam int DIST_W      = 10;
    localparam int GAP_W       = 18;
    localparam int SCALE_W     = 16;
    localparam int SCALE_SHIFT = 20;
    localparam int N_W         = 8;
    localparam int SUM_W       = 18;
    localparam int PROD_W      = TIME_BITS + SCALE_W;
    localparam int RAW_W       = PROD_W - SCALE_SHIFT;
    localparam int CMP_W       = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TMO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd5;

    // Register reset values
    localparam logic [TRIG_W-1:0]  RST_TRIG_WIDTH = 10'd10;
    localparam logic [TMO_W-1:0]   RST_ECHO_TMO   = 16'd50000;
    localparam logic [DIST_W-1:0]  RST_MIN_DIST   = 10'd2;
    localparam logic [DIST_W-1:0]  RST_MAX_DIST   = 10'd450;
    localparam logic [GAP_W-1:0]   RST_GAP        = 18'd200000;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 16'd17963;

    // Tick counter operation
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC
    } t_cnt_op;

    // Value added to the sum when a reading ends
    typedef enum logic [1:0] {
        READ_ZERO,
        READ_MAX,
        READ_MEAS
    } t_read_sel;

    // Controller to datapath
    typedef struct packed {
        logic      item_load;
        t_cnt_op   cnt_op;
        logic      series_load;
        logic      reading_end;
        t_read_sel read_sel;
        logic      div_load;
        logic      div_step;
        logic      out_load;
        logic      out_trig;
        logic      out_busy;
        logic      out_done;
        logic      out_use_quo;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kind_start;
        logic echo;
        logic n_zero;
        logic inc_ge_trig;
        logic inc_gt_tmo;
        logic inc_ge_gap;
        logic gap_zero;
        logic left_one;
        logic left_zero;
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/ultrasonic_echo_ranger_unit.sv]
// Top level of the ultrasonic echo ranger: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_kind, i_echo_level, i_sample_count
//  result  | out       | o_out_valid / i_out_stall  | o_trigger_level, o_busy_res, o_done_res,
//          |           |                            | o_distance_cm
//  config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  Each beat passes capture, step and output from accept to result register.
//  A beat that ends a series with readings adds a divider load and the 18-step restoring
//  divide of the distance sum by the sample count before the output state.
//  One beat is in flight at a time; a new beat is taken once its result is registered.
//  A stalled result holds its register and the block waits in the output state.
//  Reset (synchronous, active low) restores the register defaults and an idle series.
`default_nettype none

module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic                  i_echo_level,
    input  wire logic [N_W-1:0]        i_sample_count,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_trigger_level,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [DIST_W-1:0]          o_distance_cm
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    uer_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_echo_level    (i_echo_level),
        .i_sample_count  (i_sample_count),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_cm   (o_distance_cm)
    );

endmodule

`default_nettype wire

[rtl/core/uer_dp.sv]
// Echo ranger datapath: registers, tick counter, scaling multiply, range filter, divider.
`default_nettype none

module uer_dp
    import uer_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_kind,
    input  wire logic                  i_echo_level,
    input  wire logic [N_W-1:0]        i_sample_count,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_trigger_level,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [DIST_W-1:0]          o_distance_cm
);

    // Configuration registers
    logic [TRIG_W-1:0]  r_trig_width;
    logic [TMO_W-1:0]   r_echo_tmo;
    logic [DIST_W-1:0]  r_min_dist;
    logic [DIST_W-1:0]  r_max_dist;
    logic [GAP_W-1:0]   r_gap;
    logic [SCALE_W-1:0] r_scale;

    // Latched beat
    logic               r_kind;
    logic               r_echo;
    logic [N_W-1:0]     r_n;

    // Series state
    logic [TIME_BITS-1:0] r_cnt;
    logic [N_W-1:0]       r_left;
    logic [N_W-1:0]       r_total;
    logic [SUM_W-1:0]     r_sum;

    // Arithmetic
    logic [PROD_W-1:0]    r_prod;
    logic [N_W-1:0]       r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Result registers
    logic              r_o_trig;
    logic              r_o_busy;
    logic              r_o_done;
    logic [DIST_W-1:0] r_o_dist;

    logic [TIME_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]     inc_ext;
    logic [RAW_W-1:0]     raw_dist;
    logic                 in_range;
    logic [DIST_W-1:0]    reading;
    logic [N_W:0]         div_shift;
    logic [N_W:0]         div_diff;
    logic                 div_ge;

    // Saturating increment of the tick counter
    assign cnt_inc = (r_cnt == {TIME_BITS{1'b1}}) ? r_cnt : r_cnt + 1'b1;
    assign inc_ext = CMP_W'(cnt_inc);

    // Range filter on the scaled width
    assign raw_dist = r_prod[PROD_W-1:SCALE_SHIFT];
    assign in_range = (CMP_W'(raw_dist) >= CMP_W'(r_min_dist))
                   && (CMP_W'(raw_dist) <= CMP_W'(r_max_dist));

    always_comb begin
        case (i_cmd.read_sel)
            READ_MAX:  reading = r_max_dist;
            READ_MEAS: reading = in_range ? raw_dist[DIST_W-1:0] : '0;
            default:   reading = '0;
        endcase
    end

    // Restoring divide step: one quotient bit per cycle
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_diff  = div_shift - {1'b0, r_total};
    assign div_ge    = div_shift >= {1'b0, r_total};

    // Status to the controller
    assign o_stat.kind_start  = r_kind;
    assign o_stat.echo        = r_echo;
    assign o_stat.n_zero      = (r_n == '0);
    assign o_stat.inc_ge_trig = inc_ext >= CMP_W'(r_trig_width);
    assign o_stat.inc_gt_tmo  = inc_ext > CMP_W'(r_echo_tmo);
    assign o_stat.inc_ge_gap  = inc_ext >= CMP_W'(r_gap);
    assign o_stat.gap_zero    = (r_gap == '0);
    assign o_stat.left_one    = (r_left == N_W'(1));
    assign o_stat.left_zero   = (r_left == '0);
    assign o_stat.div_last    = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_width <= RST_TRIG_WIDTH;
            r_echo_tmo   <= RST_ECHO_TMO;
            r_min_dist   <= RST_MIN_DIST;
            r_max_dist   <= RST_MAX_DIST;
            r_gap        <= RST_GAP;
            r_scale      <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIG_WIDTH: r_trig_width <= i_cfg_data[TRIG_W-1:0];
                CFG_ECHO_TMO:   r_echo_tmo   <= i_cfg_data[TMO_W-1:0];
                CFG_MIN_DIST:   r_min_dist   <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:   r_max_dist   <= i_cfg_data[DIST_W-1:0];
                CFG_GAP:        r_gap        <= i_cfg_data[GAP_W-1:0];
                CFG_SCALE:      r_scale      <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Series state: counter, readings left, total and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_left  <= '0;
            r_total <= '0;
            r_sum   <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_CLEAR: r_cnt <= '0;
                CNT_INC:   r_cnt <= cnt_inc;
                default:   r_cnt <= r_cnt;
            endcase
            if (i_cmd.series_load) begin
                r_total <= r_n;
                r_left  <= r_n;
                r_sum   <= '0;
            end else if (i_cmd.reading_end) begin
                r_left <= r_left - 1'b1;
                r_sum  <= r_sum + SUM_W'(reading);
            end
        end
    end

    // Beat capture, product of the incremented count, divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_kind <= i_kind;
            r_echo <= i_echo_level;
            r_n    <= i_sample_count;
        end
        r_prod <= PROD_W'(cnt_inc) * PROD_W'(r_scale);
        if (i_cmd.div_load) begin
            r_quo     <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], div_ge};
            r_rem     <= div_ge ? div_diff[N_W-1:0] : div_shift[N_W-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_trig <= i_cmd.out_trig;
            r_o_busy <= i_cmd.out_busy;
            r_o_done <= i_cmd.out_done;
            r_o_dist <= (i_cmd.out_use_quo && (r_total != '0)) ? r_quo[DIST_W-1:0] : '0;
        end
    end

    assign o_trigger_level = r_o_trig;
    assign o_busy_res      = r_o_busy;
    assign o_done_res      = r_o_done;
    assign o_distance_cm   = r_o_dist;

endmodule

`default_nettype wire

[rtl/core/uer_ctrl.sv]
// Echo ranger controller: beat sequencing, measurement phase and output handshake.
`default_nettype none

`include "assert_macros.svh"

module uer_ctrl
    import uer_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DLOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG,
        PH_RISE,
        PH_MEAS,
        PH_GAP
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_fin, n_fin;
    logic   r_use_quo, n_use_quo;
    logic   r_out_valid, n_out_valid;

    logic in_acc;
    logic out_free;
    logic end_rd;
    logic leave;
    logic leave_last;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Decide the next phase and issue datapath commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_use_quo   = r_use_quo;
        n_out_valid = r_out_valid && i_out_stall;
        end_rd      = 1'b0;
        leave       = 1'b0;
        leave_last  = 1'b0;
        o_cmd       = '0;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.read_sel = READ_ZERO;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.item_load = 1'b1;
                    n_fin           = 1'b0;
                    n_use_quo       = 1'b0;
                    n_state         = S_STEP;
                end
            end
            S_STEP: begin
                n_state = S_OUT;
                if (i_stat.kind_start) begin
                    // start is dropped while a series runs
                    if (r_phase == PH_IDLE) begin
                        o_cmd.series_load = 1'b1;
                        o_cmd.cnt_op      = CNT_CLEAR;
                        if (i_stat.n_zero) begin
                            n_fin = 1'b1;
                        end else begin
                            n_phase = PH_TRIG;
                        end
                    end
                end else begin
                    case (r_phase)
                        PH_TRIG: begin
                            if (i_stat.inc_ge_trig) begin
                                n_phase      = PH_RISE;
                                o_cmd.cnt_op = CNT_CLEAR;
                            end else begin
                                o_cmd.cnt_op = CNT_INC;
                            end
                        end
                        PH_RISE: begin
                            if (i_stat.echo) begin
                                n_phase      = PH_MEAS;
                                o_cmd.cnt_op = CNT_CLEAR;
                            end else if (i_stat.inc_gt_tmo) begin
                                end_rd         = 1'b1;
                                o_cmd.read_sel = READ_ZERO;
                            end else begin
                                o_cmd.cnt_op = CNT_INC;
                            end
                        end
                        PH_MEAS: begin
                            if (!i_stat.echo) begin
                                end_rd         = 1'b1;
                                o_cmd.read_sel = READ_MEAS;
                            end else if (i_stat.inc_gt_tmo) begin
                                end_rd         = 1'b1;
                                o_cmd.read_sel = READ_MAX;
                            end else begin
                                o_cmd.cnt_op = CNT_INC;
                            end
                        end
                        PH_GAP: begin
                            if (i_stat.inc_ge_gap) begin
                                leave      = 1'b1;
                                leave_last = i_stat.left_zero;
                            end else begin
                                o_cmd.cnt_op = CNT_INC;
                            end
                        end
                        PH_IDLE: ;
                        default: n_phase = PH_IDLE;
                    endcase

                    // Close a reading; an empty gap leaves it at once
                    if (end_rd) begin
                        o_cmd.reading_end = 1'b1;
                        o_cmd.cnt_op      = CNT_CLEAR;
                        n_phase           = PH_GAP;
                        if (i_stat.gap_zero) begin
                            leave      = 1'b1;
                            leave_last = i_stat.left_one;
                        end
                    end

                    // Finish the series or trigger the next reading
                    if (leave) begin
                        o_cmd.cnt_op = CNT_CLEAR;
                        if (leave_last) begin
                            n_phase   = PH_IDLE;
                            n_fin     = 1'b1;
                            n_use_quo = 1'b1;
                            n_state   = S_DLOAD;
                        end else begin
                            n_phase = PH_TRIG;
                        end
                    end
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_trig    = (r_phase == PH_TRIG);
                    o_cmd.out_busy    = (r_phase != PH_IDLE);
                    o_cmd.out_done    = r_fin;
                    o_cmd.out_use_quo = r_use_quo;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_fin       <= 1'b0;
            r_use_quo   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_use_quo   <= n_use_quo;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `UER_ASSERT_NEXT(a_acc_to_step, in_acc, r_state == S_STEP, "accepted beat did not reach step")
    `UER_ASSERT_NEXT(a_phase_only_in_step, r_state != S_STEP, $stable(r_phase), "phase moved outside step")
    `UER_ASSERT_NEXT(a_dload_to_div, r_state == S_DLOAD, r_state == S_DIV, "divider load not followed by divide")
    `UER_ASSERT_NEXT(a_div_end, (r_state == S_DIV) && i_stat.div_last, r_state == S_OUT, "divide did not end in output")
    `UER_ASSERT_NOW(a_out_from_out, $rose(r_out_valid), $past(r_state) == S_OUT, "result raised outside output state")

endmodule

`default_nettype wire

[tb/uer_tb_pkg.sv]
// Tracker that predicts the echo ranger status beats and checks them in order.
package uer_tb_pkg;

    import uer_pkg::*;

    typedef enum logic {
        ITEM_TICK  = 1'b0,
        ITEM_START = 1'b1
    } t_item_kind;

    typedef enum logic [2:0] {
        RNG_IDLE,
        RNG_TRIGGER,
        RNG_WAIT_RISE,
        RNG_MEASURE,
        RNG_GAP
    } t_ranger_phase;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] dist_cm;
    } t_ranger_status;

    class range_series_tracker;

        // Register copies
        logic [TRIG_W-1:0]    trig_width;
        logic [TMO_W-1:0]     echo_tmo;
        logic [DIST_W-1:0]    min_cm;
        logic [DIST_W-1:0]    max_cm;
        logic [GAP_W-1:0]     gap_len;
        logic [SCALE_W-1:0]   scale;

        // Series state
        t_ranger_phase        phase;
        logic [TIME_BITS-1:0] ticks;
        logic [N_W-1:0]       readings_left;
        logic [N_W-1:0]       readings_total;
        logic [SUM_W-1:0]     dist_sum;
        logic                 fin;
        logic [DIST_W-1:0]    fin_cm;

        t_ranger_status       expected_status[$];
        int unsigned          mismatches;

        function new();
            trig_width     = RST_TRIG_WIDTH;
            echo_tmo       = RST_ECHO_TMO;
            min_cm         = RST_MIN_DIST;
            max_cm         = RST_MAX_DIST;
            gap_len        = RST_GAP;
            scale          = RST_SCALE;
            phase          = RNG_IDLE;
            ticks          = '0;
            readings_left  = '0;
            readings_total = '0;
            dist_sum       = '0;
            mismatches     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TRIG_WIDTH: trig_width = data[TRIG_W-1:0];
                CFG_ECHO_TMO:   echo_tmo   = data[TMO_W-1:0];
                CFG_MIN_DIST:   min_cm     = data[DIST_W-1:0];
                CFG_MAX_DIST:   max_cm     = data[DIST_W-1:0];
                CFG_GAP:        gap_len    = data[GAP_W-1:0];
                CFG_SCALE:      scale      = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function bit series_idle();
            return phase == RNG_IDLE;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        // Saturate at all ones
        function void count_tick();
            if (ticks != '1) ticks++;
        endfunction

        function void start_reading();
            phase = RNG_TRIGGER;
            ticks = '0;
        endfunction

        // Finish the series or fire the next trigger
        function void leave_gap();
            logic [SUM_W-1:0] quo;
            if (readings_left == 0) begin
                quo    = (readings_total != 0) ? dist_sum / SUM_W'(readings_total) : '0;
                fin    = 1'b1;
                fin_cm = quo[DIST_W-1:0];
                phase  = RNG_IDLE;
                ticks  = '0;
            end else begin
                start_reading();
            end
        endfunction

        function void end_reading(logic [DIST_W-1:0] cm);
            dist_sum      = dist_sum + SUM_W'(cm);
            readings_left = readings_left - 1'b1;
            phase         = RNG_GAP;
            ticks         = '0;
            if (ticks >= gap_len) leave_gap();
        endfunction

        // Advance the series by one accepted beat and queue its status
        function void take_beat(t_item_kind kind, logic echo, logic [N_W-1:0] n);
            logic [PROD_W-1:0] prod;
            logic [RAW_W-1:0]  raw;
            t_ranger_status    st;
            fin    = 1'b0;
            fin_cm = '0;
            if (kind == ITEM_START) begin
                if (phase == RNG_IDLE) begin
                    readings_total = n;
                    readings_left  = n;
                    dist_sum       = '0;
                    ticks          = '0;
                    if (n == 0) begin
                        fin    = 1'b1;
                        fin_cm = '0;
                    end else begin
                        start_reading();
                    end
                end
            end else begin
                case (phase)
                    RNG_TRIGGER: begin
                        count_tick();
                        if (ticks >= trig_width) begin
                            phase = RNG_WAIT_RISE;
                            ticks = '0;
                        end
                    end
                    RNG_WAIT_RISE: begin
                        if (echo) begin
                            phase = RNG_MEASURE;
                            ticks = '0;
                        end else begin
                            count_tick();
                            if (ticks > echo_tmo) end_reading('0);
                        end
                    end
                    RNG_MEASURE: begin
                        count_tick();
                        if (!echo) begin
                            prod = PROD_W'(ticks) * PROD_W'(scale);
                            raw  = prod[PROD_W-1:SCALE_SHIFT];
                            if (raw < min_cm || raw > max_cm) end_reading('0);
                            else end_reading(raw[DIST_W-1:0]);
                        end else if (ticks > echo_tmo) begin
                            end_reading(max_cm);
                        end
                    end
                    RNG_GAP: begin
                        count_tick();
                        if (ticks >= gap_len) leave_gap();
                    end
                    default: phase = RNG_IDLE;
                endcase
            end
            st.trig    = (phase == RNG_TRIGGER);
            st.busy    = (phase != RNG_IDLE);
            st.done    = fin;
            st.dist_cm = fin ? fin_cm : '0;
            expected_status.push_back(st);
        endfunction

        // Compare one result beat against the oldest prediction
        function void match_result(t_ranger_status got);
            t_ranger_status want;
            if (expected_status.size() == 0) begin
                $error("result beat with nothing pending: trig %0d busy %0d done %0d dist %0d",
                       got.trig, got.busy, got.done, got.dist_cm);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (got.trig !== want.trig) begin
                $error("trigger_level expected %0d actual %0d", want.trig, got.trig);
                mismatches++;
            end
            if (got.busy !== want.busy) begin
                $error("busy_res expected %0d actual %0d", want.busy, got.busy);
                mismatches++;
            end
            if (got.done !== want.done) begin
                $error("done_res expected %0d actual %0d", want.done, got.done);
                mismatches++;
            end
            if (got.dist_cm !== want.dist_cm) begin
                $error("distance_cm expected %0d actual %0d", want.dist_cm, got.dist_cm);
                mismatches++;
            end
        endfunction

    endclass

endpackage

[tb/tb_ultrasonic_echo_ranger_unit.sv]
// Testbench top for the echo ranger: directed and random series with random stalls.
module tb_ultrasonic_echo_ranger_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;
    import uer_tb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_kind;
    logic                  i_echo_level;
    logic [N_W-1:0]        i_sample_count;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_trigger_level;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [DIST_W-1:0]     o_distance_cm;

    range_series_tracker   tracker;
    int unsigned           idle_max;
    int unsigned           hold_off_req;
    int unsigned           beats_sent;

    ultrasonic_echo_ranger_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_echo_level    (i_echo_level),
        .i_sample_count  (i_sample_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_cm   (o_distance_cm)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned pause_len();
        return $urandom_range(0, idle_max);
    endfunction

    // Offer one input beat and hold it until accepted; returns on the next falling edge
    task automatic send_beat(t_item_kind kind, logic echo, logic [N_W-1:0] n);
        int unsigned pause;
        pause = pause_len();
        if (pause != 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_echo_level   <= echo;
        i_sample_count <= n;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.take_beat(kind, echo, n);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(logic level, int unsigned count, bit scramble);
        for (int unsigned i = 0; i < count; i++) begin
            send_beat(ITEM_TICK, scramble ? 1'($urandom_range(0, 1)) : level,
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        tracker.set_reg(idx, CFG_DATA_W'(data));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_regs(int unsigned trig, int unsigned tmo, int unsigned min_d,
                                int unsigned max_d, int unsigned gap, int unsigned scl);
        write_reg(CFG_TRIG_WIDTH, trig);
        write_reg(CFG_ECHO_TMO, tmo);
        write_reg(CFG_MIN_DIST, min_d);
        write_reg(CFG_MAX_DIST, max_d);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_SCALE, scl);
    endtask

    // Finish any open series, drop valid and drain all pending results
    task automatic settle();
        while (!tracker.series_idle()) send_beat(ITEM_TICK, 1'b0, 8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Start a series and play echo waveforms that follow the current settings
    task automatic run_series(logic [N_W-1:0] n);
        int unsigned tmo;
        int unsigned trig_ticks;
        int unsigned rise_len;
        tmo        = tracker.echo_tmo;
        trig_ticks = (tracker.trig_width == 0) ? 1 : tracker.trig_width;
        send_beat(ITEM_START, 1'($urandom_range(0, 1)), n);
        for (int k = 0; k < n; k++) begin
            // Cut a short series off now and then
            if (n < 20 && $urandom_range(0, 39) == 0) return;
            send_ticks(1'b0, trig_ticks, 1'b1);
            rise_len = ($urandom_range(0, 5) == 0) ? tmo + 1
                       : $urandom_range(0, (tmo < 4) ? tmo : 4);
            if (rise_len > tmo) begin
                send_ticks(1'b0, rise_len, 1'b0);
            end else begin
                send_ticks(1'b0, rise_len, 1'b0);
                send_ticks(1'b1, 1, 1'b0);
                if ($urandom_range(0, 7) == 0) begin
                    send_ticks(1'b1, tmo + 1, 1'b0);
                end else begin
                    send_ticks(1'b1, $urandom_range(0, tmo), 1'b0);
                    send_ticks(1'b0, 1, 1'b0);
                end
            end
            send_ticks(1'b0, tracker.gap_len, 1'b1);
        end
    endtask

    // Result side: random stall per beat, with one long hold-off on request
    initial begin
        int unsigned stall_len;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req != 0) begin
                stall_len    = hold_off_req;
                hold_off_req = 0;
            end else begin
                stall_len = pause_len();
            end
            if (stall_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall == 1'b0));
            tracker.match_result({o_trigger_level, o_busy_res, o_done_res, o_distance_cm});
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        int unsigned rand_base;
        int unsigned ph_base;
        int unsigned ph;
        int unsigned roll;
        tracker        = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = 1'b0;
        i_echo_level   = 1'b0;
        i_sample_count = '0;
        i_out_stall    = 1'b0;
        idle_max       = 13;
        hold_off_req   = 0;
        beats_sent     = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ticks while idle, then an empty series, on reset settings
        send_beat(ITEM_TICK, 1'b0, 8'h00);
        send_beat(ITEM_TICK, 1'b1, 8'hFF);
        send_beat(ITEM_START, 1'b1, 8'h00);

        // Register extremes with idle traffic only
        settle();
        program_regs(1023, 65535, 1023, 0, 262143, 0);
        send_beat(ITEM_START, 1'b0, 8'h00);
        send_beat(ITEM_TICK, 1'b1, 8'h55);

        // Zero trigger width and zero gap: rise timeout, high timeout, short echo
        settle();
        program_regs(0, 3, 0, 1023, 0, 65535);
        send_beat(ITEM_START, 1'b0, 8'd3);
        send_beat(ITEM_START, 1'b1, 8'hFF);
        send_ticks(1'b0, 5, 1'b0);
        send_ticks(1'b0, 1, 1'b0);
        send_ticks(1'b1, 5, 1'b0);
        send_ticks(1'b0, 1, 1'b0);
        send_ticks(1'b1, 2, 1'b0);
        send_ticks(1'b0, 1, 1'b0);

        // One long echo after a wide trigger, no idling
        settle();
        idle_max = 0;
        program_regs(40, 65535, 0, 1023, 2, 65535);
        send_beat(ITEM_START, 1'b0, 8'd1);
        send_ticks(1'b0, 40, 1'b1);
        send_ticks(1'b1, 1, 1'b0);
        send_ticks(1'b1, $urandom_range(100, 160), 1'b0);
        send_ticks(1'b0, 1, 1'b0);
        send_ticks(1'b0, 2, 1'b1);

        // Random phases, each with fresh settings
        rand_base = beats_sent;
        ph        = 0;
        while (beats_sent - rand_base < 1000) begin
            settle();
            idle_max = (ph % 3 == 1) ? 0 : 13;
            roll     = $urandom_range(0, 3);
            program_regs($urandom_range(0, 6),
                         (ph % 2 == 1) ? $urandom_range(1, 120) : $urandom_range(1, 30),
                         $urandom_range(0, 4),
                         ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8)
                                                     : $urandom_range(0, 1023),
                         $urandom_range(0, 6),
                         (roll == 0) ? 65535 : (roll == 1) ? 0 : $urandom_range(0, 65535));
            if (ph == 2) hold_off_req = 400;
            if (ph == 3) begin
                // Long series of quick readings to load the divider
                program_regs(1, 4, 0, 1023, 1, $urandom_range(0, 65535));
                run_series(8'($urandom_range(128, 136)));
            end
            ph_base = beats_sent;
            while (beats_sent - ph_base < 150) begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    run_series((roll < 8) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(1, 4)));
                end else if (roll < 94) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_beat(t_item_kind'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)));
                    end
                end else begin
                    send_beat(ITEM_START, 1'($urandom_range(0, 1)), 8'h00);
                end
            end
            ph++;
        end

        // Drain and let the block go quiet
        settle();
        repeat (30) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
